// File: design/bpi_pkg.sv
// Shared constants for the bicubic patch interpolator and its checker.
package bpi_pkg;

    // Default geometry of the offsets and the samples.
    localparam int FRAC_BITS_DEF   = 8;
    localparam int SAMPLE_BITS_DEF = 8;

    // Fractional bits of the rounded weights and of the result.
    localparam int WBITS    = 16;
    localparam int OUT_FRAC = 8;

    // Result field and its saturation bounds.
    localparam int OUT_W   = 18;
    localparam int OUT_MIN = -131072;
    localparam int OUT_MAX = 131071;

    // Input field widths.
    localparam int ROW_W  = 32;
    localparam int FRAC_W = 8;
    localparam int PATCH_N = 4;

    // Stream widths, padded to whole bytes.
    localparam int S_TDATA_W = PATCH_N * ROW_W + 2 * FRAC_W;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Number of register stages from the input to the output register.
    localparam int NSTG = 9;

endpackage

// File: design/bicubic_patch_interpolator_core.sv
// Top level of the pipelined Catmull-Rom bicubic patch interpolator.
//
// The block takes one request per clock cycle on the slave stream: a 4x4
// patch of unsigned samples and two unsigned fractional offsets, and returns
// one signed interpolated value with 8 fractional bits on the master stream.
// The nine register stages are: offset squares, offset cubes, the exact
// cubic numerators, the rounded weights, the sixteen sample-by-weight
// products, the four row sums, the four row-by-weight products, the final
// sum and, last, the rounded and saturated output register. Every stage
// carries its own valid bit and is loaded whenever it is empty or the
// stage after it moves on, so a stall on the master side holds the results
// in place while empty stages further up keep filling; the slave side is
// refused only once every stage is full. A stage costs at most one
// multiplier or one wide add. The block takes one request per cycle
// while the master side takes its results. The offset x weights the rows
// (first index), the offset y weights the columns; the result is not
// clamped to the sample range and only saturates at the bounds of the
// 18-bit field.
module bicubic_patch_interpolator_core
    import bpi_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Slave stream, fields from bit 0 up: patch_row_0, patch_row_1,
    // patch_row_2, patch_row_3, frac_x, frac_y.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // Master stream, fields from bit 0 up: interpolated_value, zero padding.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    // Widths derived from the parameters.
    localparam int F    = FRAC_BITS;
    localparam int SB   = SAMPLE_BITS;
    localparam int UB   = (F < FRAC_W) ? F : FRAC_W;
    localparam int ROWX = PATCH_N * SB;
    localparam int NW   = 3 * F + 5;
    localparam int SC   = 3 * F + 1;
    localparam int RSH  = (SC > WBITS) ? SC - WBITS : 1;
    localparam int LSH  = (SC > WBITS) ? 0 : WBITS - SC;
    localparam int TW   = NW + LSH;
    localparam int WW   = WBITS + 2;
    localparam int PW   = WW + SB + 1;
    localparam int SSW  = PW + 2;
    localparam int QW   = WW + SSW;
    localparam int AW   = QW + 2;
    localparam int OSH  = 2 * WBITS - OUT_FRAC;
    localparam int RW   = AW - OSH;

    typedef logic [SB-1:0] sample_t;
    typedef logic signed [WW-1:0] weight_t;

    localparam logic signed [NW-1:0] D3X2 = NW'(1) <<< (3 * F + 1);
    localparam logic signed [AW-1:0] OUT_HALF = AW'(1) <<< (OSH - 1);
    localparam logic signed [RW-1:0] R_MAX = RW'(OUT_MAX);
    localparam logic signed [RW-1:0] R_MIN = RW'(OUT_MIN);

    // ------------------------------------------------------------------
    // Valid bits and the load chain. A stage loads when it is empty or
    // the next stage loads; the output stage loads when it is empty or
    // its result is being taken.
    // ------------------------------------------------------------------
    logic [NSTG:1] valid_reg;
    logic [NSTG:1] valid_next;
    logic [NSTG:1] load;

    always_comb
    begin
        load[NSTG] = !valid_reg[NSTG] || m_tready;
        for (int k = NSTG - 1; k >= 1; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
        valid_next[1] = load[1] ? s_tvalid : valid_reg[1];
        for (int k = 2; k <= NSTG; k++)
        begin
            valid_next[k] = load[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = load[1];

    // ------------------------------------------------------------------
    // Input unpacking.
    // ------------------------------------------------------------------
    logic [F-1:0] in_ux;
    logic [F-1:0] in_uy;
    sample_t      in_p [PATCH_N][PATCH_N];

    always_comb
    begin
        logic [ROWX-1:0] row_ext;
        in_ux = F'(s_tdata[PATCH_N*ROW_W +: UB]);
        in_uy = F'(s_tdata[PATCH_N*ROW_W + FRAC_W +: UB]);
        for (int i = 0; i < PATCH_N; i++)
        begin
            // Samples reaching past the row word read the missing bits as zero.
            row_ext = ROWX'(s_tdata[i*ROW_W +: ROW_W]);
            for (int j = 0; j < PATCH_N; j++)
            begin
                in_p[i][j] = row_ext[j*SB +: SB];
            end
        end
    end

    // Samples travel alongside the weight computation until stage five.
    sample_t p1_reg [PATCH_N][PATCH_N];
    sample_t p2_reg [PATCH_N][PATCH_N];
    sample_t p3_reg [PATCH_N][PATCH_N];
    sample_t p4_reg [PATCH_N][PATCH_N];

    // ------------------------------------------------------------------
    // Stage 1: offsets and their squares.
    // ------------------------------------------------------------------
    logic [F-1:0]   ux1_reg, uy1_reg;
    logic [2*F-1:0] ux2_1_reg, uy2_1_reg;

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            ux1_reg   <= in_ux;
            uy1_reg   <= in_uy;
            ux2_1_reg <= in_ux * in_ux;
            uy2_1_reg <= in_uy * in_uy;
            p1_reg    <= in_p;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: cubes of the offsets.
    // ------------------------------------------------------------------
    logic [F-1:0]   ux2_reg, uy2_reg;
    logic [2*F-1:0] ux2_2_reg, uy2_2_reg;
    logic [3*F-1:0] ux3_2_reg, uy3_2_reg;

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            ux2_reg   <= ux1_reg;
            uy2_reg   <= uy1_reg;
            ux2_2_reg <= ux2_1_reg;
            uy2_2_reg <= uy2_1_reg;
            ux3_2_reg <= ux2_1_reg * ux1_reg;
            uy3_2_reg <= uy2_1_reg * uy1_reg;
            p2_reg    <= p1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: exact cubic numerators at scale 2^(3F+1).
    // ------------------------------------------------------------------
    logic signed [NW-1:0] nx_next [PATCH_N];
    logic signed [NW-1:0] ny_next [PATCH_N];
    logic signed [NW-1:0] nx_reg  [PATCH_N];
    logic signed [NW-1:0] ny_reg  [PATCH_N];

    function automatic void numerators(
        input  logic [F-1:0]         u,
        input  logic [2*F-1:0]       u2,
        input  logic [3*F-1:0]       u3,
        output logic signed [NW-1:0] n0,
        output logic signed [NW-1:0] n1,
        output logic signed [NW-1:0] n2,
        output logic signed [NW-1:0] n3
    );
        logic signed [NW-1:0] su;
        logic signed [NW-1:0] su2d;
        logic signed [NW-1:0] su3;
        logic signed [NW-1:0] sudd;
        su   = $signed(NW'(u));
        su2d = $signed(NW'(u2)) <<< F;
        su3  = $signed(NW'(u3));
        sudd = su <<< (2 * F);
        n0 = (su2d <<< 1) - su3 - sudd;
        n1 = (su3 <<< 1) + su3 - (su2d <<< 2) - su2d + D3X2;
        n2 = (su2d <<< 2) + sudd - (su3 <<< 1) - su3;
        n3 = su3 - su2d;
    endfunction

    always_comb
    begin
        numerators(ux2_reg, ux2_2_reg, ux3_2_reg,
                   nx_next[0], nx_next[1], nx_next[2], nx_next[3]);
        numerators(uy2_reg, uy2_2_reg, uy3_2_reg,
                   ny_next[0], ny_next[1], ny_next[2], ny_next[3]);
    end

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            nx_reg <= nx_next;
            ny_reg <= ny_next;
            p3_reg <= p2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: weights with WBITS fractional bits, rounded to nearest with
    // ties upward.
    // ------------------------------------------------------------------
    function automatic weight_t to_weight(input logic signed [NW-1:0] n);
        logic signed [TW-1:0] t;
        if (SC > WBITS)
        begin
            t = (TW'(n) + (TW'(1) <<< (RSH - 1))) >>> RSH;
        end
        else
        begin
            t = TW'(n) <<< LSH;
        end
        return t[WW-1:0];
    endfunction

    weight_t wx4_reg [PATCH_N];
    weight_t wy4_reg [PATCH_N];

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            for (int k = 0; k < PATCH_N; k++)
            begin
                wx4_reg[k] <= to_weight(nx_reg[k]);
                wy4_reg[k] <= to_weight(ny_reg[k]);
            end
            p4_reg <= p3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: sixteen column-weight products.
    // ------------------------------------------------------------------
    logic signed [PW-1:0] prod_reg [PATCH_N][PATCH_N];
    weight_t              wx5_reg  [PATCH_N];

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            for (int i = 0; i < PATCH_N; i++)
            begin
                for (int j = 0; j < PATCH_N; j++)
                begin
                    prod_reg[i][j] <= PW'(wy4_reg[j] * $signed({1'b0, p4_reg[i][j]}));
                end
            end
            wx5_reg <= wx4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: row sums, exact with WBITS fractional bits.
    // ------------------------------------------------------------------
    logic signed [SSW-1:0] rsum_reg [PATCH_N];
    weight_t               wx6_reg  [PATCH_N];

    always_ff @(posedge clk)
    begin
        if (load[6])
        begin
            for (int i = 0; i < PATCH_N; i++)
            begin
                rsum_reg[i] <= SSW'(prod_reg[i][0]) + SSW'(prod_reg[i][1])
                             + SSW'(prod_reg[i][2]) + SSW'(prod_reg[i][3]);
            end
            wx6_reg <= wx5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: row sums times row weights.
    // ------------------------------------------------------------------
    logic signed [QW-1:0] rprod_reg [PATCH_N];

    always_ff @(posedge clk)
    begin
        if (load[7])
        begin
            for (int i = 0; i < PATCH_N; i++)
            begin
                rprod_reg[i] <= QW'(wx6_reg[i] * rsum_reg[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: exact total with 2*WBITS fractional bits.
    // ------------------------------------------------------------------
    logic signed [AW-1:0] acc_reg;

    always_ff @(posedge clk)
    begin
        if (load[8])
        begin
            acc_reg <= AW'(rprod_reg[0]) + AW'(rprod_reg[1])
                     + AW'(rprod_reg[2]) + AW'(rprod_reg[3]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: round to OUT_FRAC fractional bits and saturate.
    // ------------------------------------------------------------------
    logic signed [AW-1:0]    acc_rnd;
    logic signed [RW-1:0]    res_full;
    logic signed [OUT_W-1:0] res_next;
    logic signed [OUT_W-1:0] res_reg;

    always_comb
    begin
        acc_rnd  = (acc_reg + OUT_HALF) >>> OSH;
        res_full = acc_rnd[RW-1:0];
        if (res_full > R_MAX)
        begin
            res_next = OUT_W'(OUT_MAX);
        end
        else if (res_full < R_MIN)
        begin
            res_next = OUT_W'(OUT_MIN);
        end
        else
        begin
            res_next = res_full[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[9])
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = valid_reg[NSTG];
    assign m_tdata  = M_TDATA_W'($unsigned(res_reg));

endmodule

// File: design/bpi_checker.sv
// Port-level checker for the bicubic patch interpolator, with its bind.
module bpi_checker
    import bpi_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result stays put until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or vanished");

    // Requests are refused only while a finished result is held back.
    a_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("slave side refused with the master side free");

    // No result is shown while the block is held in reset.
    a_reset: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result shown during reset");

    // With the master side ready throughout, a request comes out as a result
    // once it has passed through all NSTG register stages.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready ##1 m_tready [* NSTG - 1] |=> m_tvalid)
        else $error("result missing after the pipeline latency");

endmodule

bind bicubic_patch_interpolator_core bpi_checker u_bpi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
